// ===== src/rtmp_chunk_packetizer_macros.svh =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef RTMP_CHUNK_PACKETIZER_MACROS_SVH
`define RTMP_CHUNK_PACKETIZER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtmp chunk packetizer check failed");

// The consequent holds in the cycle after the antecedent.
`define RCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtmp chunk packetizer check failed");

`endif

// ===== src/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer package
// Shared constants and the queue entry type between front and back parts.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int unsigned CsidSlotsDef = 1024;
  localparam int unsigned NumPos       = 19;
  localparam logic [4:0]  PosBody      = 5'd18;
  localparam logic [16:0] ChunkSizeRst = 17'd128;
  localparam logic [23:0] ExtTsMark    = 24'hffffff;

  typedef logic [NumPos-1:0] pos_vec_t;

  typedef struct packed {
    pos_vec_t    present;
    logic        err;
    logic        hdr_only;
    logic [1:0]  fmt;
    logic [1:0]  basic_len;
    logic [5:0]  csid_lo;
    logic [15:0] csid_m;
    logic [23:0] ts_field;
    logic [31:0] tm;
    logic [23:0] plen;
    logic [7:0]  mtype;
    logic [31:0] sid;
    logic [7:0]  body;
    logic        chunk_end;
    logic        message_end;
  } entry_t;

endpackage

// ===== src/rtmp_chunk_packetizer.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer
// Turns message body bytes into chunk stream bytes with chunk headers.
// ----------------------------------------------------------------------------
// Each accepted item yields one body byte (none for an empty message),
// preceded at a chunk start by a header of one to eighteen bytes; the
// output runs at one byte per cycle while out_ready_i is high, so body
// items stream at one per cycle and the input stalls for the length of each
// header burst. Per chunk stream state lives in a single-port-write memory
// of CSID_SLOTS rows read at accept, with the last write forwarded, and a
// two-entry queue separates classification from the output byte walk. A
// reset pass clears all rows before any item; cfg writes are always taken.
module rtmp_chunk_packetizer #(
  parameter int unsigned CSID_SLOTS = rcp_pkg::CsidSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [16:0] chunk_stream_id_i,
  input  logic [31:0] message_stream_id_i,
  input  logic [7:0]  message_type_i,
  input  logic [23:0] payload_length_i,
  input  logic [31:0] time_stamp_i,
  input  logic [7:0]  body_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        chunk_end_o,
  output logic        message_end_o,
  output logic        error_flag_o
);
  import rcp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  rcp_front #(
    .CSID_SLOTS(CSID_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .chunk_stream_id_i,
    .message_stream_id_i,
    .message_type_i,
    .payload_length_i,
    .time_stamp_i,
    .body_byte_i,
    .push_o(push),
    .push_entry_o(push_entry),
    .full_i(full)
  );

  rcp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .push_entry_i(push_entry),
    .full_o(full),
    .pop_i(pop),
    .head_valid_o(head_valid),
    .head_o(head)
  );

  rcp_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i(head_valid),
    .head_i(head),
    .pop_o(pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .last_of_run_o,
    .chunk_end_o,
    .message_end_o,
    .error_flag_o
  );

endmodule

// ===== src/rcp_front.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer front part
// Accepts items, reads the chunk stream slot, picks the header type and
// pushes one classified entry per item into the queue.
// ----------------------------------------------------------------------------
module rcp_front #(
  parameter int unsigned CSID_SLOTS = rcp_pkg::CsidSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [16:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [16:0]     chunk_stream_id_i,
  input  logic [31:0]     message_stream_id_i,
  input  logic [7:0]      message_type_i,
  input  logic [23:0]     payload_length_i,
  input  logic [31:0]     time_stamp_i,
  input  logic [7:0]      body_byte_i,
  output logic            push_o,
  output rcp_pkg::entry_t push_entry_o,
  input  logic            full_i
);
  import rcp_pkg::*;

  localparam int unsigned AW = $clog2(CSID_SLOTS);
  localparam logic [17:0] SlotsW = 18'(CSID_SLOTS);
  localparam logic [AW-1:0] LastSlot = AW'(CSID_SLOTS - 1);

  typedef struct packed {
    logic        valid;
    logic [31:0] stream;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] time_v;
    logic [23:0] bytes;
    logic [16:0] left;
  } row_t;

  row_t mem [CSID_SLOTS];

  logic [16:0] csz_q;
  logic        clearing_q;
  logic [AW-1:0] clr_q;
  logic        s1_valid_q;
  logic [16:0] csid_q;
  logic [31:0] sid_q;
  logic [7:0]  mtype_q;
  logic [23:0] plen_q;
  logic [31:0] ts_q;
  logic [7:0]  body_q;
  row_t        rd_q;
  logic [AW-1:0] fwd_addr_q;
  row_t        fwd_row_q;

  logic        in_acc;
  logic        s1_adv;
  logic [AW-1:0] s1_addr;
  row_t        cur;
  row_t        nrow;
  logic        err;
  logic        hdr;
  logic [1:0]  fmt;
  logic [31:0] tm;
  logic        ext;
  logic        hdr_only;
  logic [16:0] csz;
  logic [23:0] rem;
  logic [16:0] left0;
  logic [16:0] left1;
  logic [23:0] bs1;
  logic        msg_done;
  logic [1:0]  blen;
  logic        we;
  logic [AW-1:0] wa;
  row_t        wd;
  entry_t      ent;

  assign s1_addr = csid_q[AW-1:0];
  assign s1_adv  = s1_valid_q && !full_i;
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc  = in_valid_i && in_ready_o;
  assign cur     = (fwd_addr_q == s1_addr) ? fwd_row_q : rd_q;
  assign err     = (csid_q < 17'd2) || ({1'b0, csid_q} >= SlotsW);
  assign csz     = (csz_q == 17'd0) ? 17'd1 : csz_q;

  always_comb begin
    hdr = (cur.left == 17'd0);
    fmt = 2'd0;
    if (cur.bytes != 24'd0) begin
      fmt = 2'd3;
    end else if (cur.valid && cur.stream == sid_q) begin
      fmt = 2'd1;
      if (cur.len == plen_q && cur.mtype == mtype_q) begin
        fmt = 2'd2;
        if (cur.time_v == ts_q) begin
          fmt = 2'd3;
        end
      end
    end
    tm  = (fmt == 2'd0) ? ts_q : ts_q - cur.time_v;
    ext = (fmt != 2'd3) && (tm >= {8'd0, ExtTsMark});
    hdr_only = hdr && (cur.bytes == 24'd0) && (plen_q == 24'd0);
    rem = (plen_q > cur.bytes) ? plen_q - cur.bytes : 24'd1;
    if (!hdr) begin
      left0 = cur.left;
    end else if (rem < {7'd0, csz}) begin
      left0 = rem[16:0];
    end else begin
      left0 = csz;
    end
    left1 = left0 - 17'd1;
    bs1   = cur.bytes + 24'd1;
    msg_done = (bs1 >= plen_q) || (bs1 == 24'd0);
    if (csid_q <= 17'd63) begin
      blen = 2'd1;
    end else if (csid_q <= 17'd319) begin
      blen = 2'd2;
    end else begin
      blen = 2'd3;
    end

    nrow = cur;
    if (hdr) begin
      nrow.valid  = 1'b1;
      nrow.stream = sid_q;
      nrow.len    = plen_q;
      nrow.mtype  = mtype_q;
      nrow.time_v = ts_q;
    end
    if (!hdr_only) begin
      nrow.bytes = msg_done ? 24'd0 : bs1;
      nrow.left  = msg_done ? 17'd0 : left1;
    end

    ent = '0;
    if (err) begin
      ent.err = 1'b1;
      ent.present[PosBody] = 1'b1;
    end else begin
      ent.present[0]     = hdr;
      ent.present[1]     = hdr && (blen != 2'd1);
      ent.present[2]     = hdr && (blen == 2'd3);
      ent.present[5:3]   = {3{hdr && (fmt != 2'd3)}};
      ent.present[9:6]   = {4{hdr && (fmt[1] == 1'b0)}};
      ent.present[13:10] = {4{hdr && (fmt == 2'd0)}};
      ent.present[17:14] = {4{hdr && ext}};
      ent.present[PosBody] = !hdr_only;
      ent.hdr_only    = hdr_only;
      ent.fmt         = fmt;
      ent.basic_len   = blen;
      ent.csid_lo     = csid_q[5:0];
      ent.csid_m      = 16'(csid_q - 17'd64);
      ent.ts_field    = ext ? ExtTsMark : tm[23:0];
      ent.tm          = tm;
      ent.plen        = plen_q;
      ent.mtype       = mtype_q;
      ent.sid         = sid_q;
      ent.body        = body_q;
      ent.chunk_end   = msg_done || (left1 == 17'd0);
      ent.message_end = msg_done;
    end

    we = clearing_q || (s1_adv && !err);
    wa = clearing_q ? clr_q : s1_addr;
    wd = clearing_q ? row_t'('0) : nrow;
  end

  assign push_o       = s1_adv;
  assign push_entry_o = ent;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (in_acc) begin
      rd_q <= mem[chunk_stream_id_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      fwd_addr_q <= wa;
      fwd_row_q  <= wd;
    end
    if (in_acc) begin
      csid_q  <= chunk_stream_id_i;
      sid_q   <= message_stream_id_i;
      mtype_q <= message_type_i;
      plen_q  <= payload_length_i;
      ts_q    <= time_stamp_i;
      body_q  <= body_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csz_q      <= ChunkSizeRst;
      clearing_q <= 1'b1;
      clr_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        csz_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == LastSlot) begin
          clearing_q <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rcp_queue.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer queue
// Two-entry queue that decouples classification from byte output.
// ----------------------------------------------------------------------------
module rcp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rcp_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output rcp_pkg::entry_t head_o
);
  import rcp_pkg::*;

  entry_t     ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/rcp_back.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer back part
// Walks the header and body positions of the queue head, one byte a cycle
// while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module rcp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  rcp_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            chunk_end_o,
  output logic            message_end_o,
  output logic            error_flag_o
);
  import rcp_pkg::*;

  logic       fresh_q;
  logic [4:0] pos_q;
  logic       ov_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       ce_q;
  logic       me_q;
  logic       err_q;

  logic       emit;
  logic [4:0] cur_pos;
  pos_vec_t   above;
  logic [4:0] nxt;
  logic       is_last;
  logic [7:0] b;

  assign cur_pos = fresh_q ? (head_i.present[0] ? 5'd0 : PosBody) : pos_q;
  assign emit    = head_valid_i && (!ov_q || out_ready_i);
  assign above   = head_i.present & ~((NumPos'(2) << cur_pos) - NumPos'(1));
  assign is_last = (above == '0);
  assign pop_o   = emit && is_last;

  always_comb begin
    nxt = PosBody;
    for (int i = NumPos - 1; i >= 0; i--) begin
      if (above[i]) begin
        nxt = 5'(i);
      end
    end
  end

  always_comb begin
    unique case (cur_pos)
      5'd0: begin
        unique case (head_i.basic_len)
          2'd1:    b = {head_i.fmt, head_i.csid_lo};
          2'd2:    b = {head_i.fmt, 6'd0};
          default: b = {head_i.fmt, 6'd1};
        endcase
      end
      5'd1:  b = head_i.csid_m[7:0];
      5'd2:  b = head_i.csid_m[15:8];
      5'd3:  b = head_i.ts_field[23:16];
      5'd4:  b = head_i.ts_field[15:8];
      5'd5:  b = head_i.ts_field[7:0];
      5'd6:  b = head_i.plen[23:16];
      5'd7:  b = head_i.plen[15:8];
      5'd8:  b = head_i.plen[7:0];
      5'd9:  b = head_i.mtype;
      5'd10: b = head_i.sid[7:0];
      5'd11: b = head_i.sid[15:8];
      5'd12: b = head_i.sid[23:16];
      5'd13: b = head_i.sid[31:24];
      5'd14: b = head_i.tm[31:24];
      5'd15: b = head_i.tm[23:16];
      5'd16: b = head_i.tm[15:8];
      5'd17: b = head_i.tm[7:0];
      default: b = head_i.body;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= b;
      last_q <= is_last;
      err_q  <= head_i.err;
      if (cur_pos == PosBody) begin
        ce_q <= head_i.chunk_end;
        me_q <= head_i.message_end;
      end else begin
        ce_q <= is_last && head_i.hdr_only;
        me_q <= is_last && head_i.hdr_only;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      pos_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (emit) begin
        ov_q    <= 1'b1;
        fresh_q <= is_last;
        pos_q   <= nxt;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = err_q ? 8'd0 : byte_q;
  assign last_of_run_o = last_q;
  assign chunk_end_o   = ce_q && !err_q;
  assign message_end_o = me_q && !err_q;
  assign error_flag_o  = err_q;

endmodule

// ===== src/rcp_checker.sv =====
// ----------------------------------------------------------------------------
// RTMP chunk packetizer port checker
// Checks output flag consistency and output stall behavior at the ports.
// ----------------------------------------------------------------------------
`include "rtmp_chunk_packetizer_macros.svh"

module rcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o,
  input logic       chunk_end_o,
  input logic       message_end_o,
  input logic       error_flag_o
);

  `RCP_ASSERT_NOW(a_err_single, out_valid_o && error_flag_o,
    last_of_run_o && out_byte_o == 8'd0 && !chunk_end_o && !message_end_o)
  `RCP_ASSERT_NOW(a_msg_ends_chunk, out_valid_o && message_end_o, chunk_end_o)
  `RCP_ASSERT_NOW(a_chunk_end_last, out_valid_o && chunk_end_o, last_of_run_o)
  `RCP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))

endmodule

bind rtmp_chunk_packetizer rcp_checker u_rcp_checker (.*);
